// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: design/brf_pkg.sv
// Types, constants and register mapping for the banked register file.
package brf_pkg;

  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = 5;
  localparam int MODE_W      = 3;
  localparam int PHYS_COUNT  = 38;
  localparam int SLOT_W      = $clog2(PHYS_COUNT);

  localparam logic [IDX_W-1:0] LAST_INDEX = 5'h11;
  localparam logic [IDX_W-1:0] IDX_R8     = 5'd8;
  localparam logic [IDX_W-1:0] IDX_R13    = 5'd13;
  localparam logic [IDX_W-1:0] IDX_R14    = 5'd14;
  localparam logic [IDX_W-1:0] IDX_SPSR   = 5'd17;

  localparam logic [MODE_W-1:0] MODE_USER  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FIQ   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SVC   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ABT   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_IRQ   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UND   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LAST  = MODE_UND;

  // Physical slots of the banked copies: FIQ r8 and SPSR, and each other bank's first entry.
  localparam logic [SLOT_W-1:0] FIQ_R8_SLOT   = 6'd18;
  localparam logic [SLOT_W-1:0] FIQ_SPSR_SLOT = 6'd25;
  localparam logic [SLOT_W-1:0] SVC_BASE      = 6'd26;
  localparam logic [SLOT_W-1:0] ABT_BASE      = 6'd29;
  localparam logic [SLOT_W-1:0] IRQ_BASE      = 6'd32;
  localparam logic [SLOT_W-1:0] UND_BASE      = 6'd35;

  typedef enum logic [1:0] {
    FUNC_READ  = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_MODE  = 2'd2,
    FUNC_NONE  = 2'd3
  } brf_func_t;

  typedef struct packed {
    brf_func_t              func;
    logic [IDX_W-1:0]       reg_index;
    logic [DATA_WIDTH-1:0]  write_data;
    logic [MODE_W-1:0]      new_mode;
  } brf_in_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0]  read_data;
    logic                   error;
  } brf_out_t;

  // Map a logical index (0..17) to its physical slot under the given mode.
  function automatic logic [SLOT_W-1:0] brf_slot(logic [IDX_W-1:0] idx,
                                                 logic [MODE_W-1:0] mode);
    logic [SLOT_W-1:0] base;
    logic              banked;
    logic [SLOT_W-1:0] slot;
    base   = SVC_BASE;
    banked = 1'b0;
    slot   = SLOT_W'(idx);
    unique case (mode)
      MODE_SVC: begin base = SVC_BASE; banked = 1'b1; end
      MODE_ABT: begin base = ABT_BASE; banked = 1'b1; end
      MODE_IRQ: begin base = IRQ_BASE; banked = 1'b1; end
      MODE_UND: begin base = UND_BASE; banked = 1'b1; end
      default:  begin base = SVC_BASE; banked = 1'b0; end
    endcase
    if (mode == MODE_FIQ) begin
      if (idx >= IDX_R8 && idx <= IDX_R14) begin
        slot = FIQ_R8_SLOT + SLOT_W'(idx - IDX_R8);
      end else if (idx == IDX_SPSR) begin
        slot = FIQ_SPSR_SLOT;
      end
    end else if (banked) begin
      if (idx == IDX_R13) begin
        slot = base;
      end else if (idx == IDX_R14) begin
        slot = base + SLOT_W'(1);
      end else if (idx == IDX_SPSR) begin
        slot = base + SLOT_W'(2);
      end
    end
    return slot;
  endfunction

endpackage

// File: design/brf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module brf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 38
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // Hold read data until the next read.
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/banked_register_file_top.sv
// Top level of the mode-banked register file.
// Banked register file: each item reads a logical register, writes one,
// changes the processor mode or does nothing, and gives exactly one result
// item. Logical indexes 0..15 are r0..r15, 16 is CPSR and 17 is SPSR; FIQ mode
// banks r8..r14 and SPSR, SVC/abort/IRQ/undefined bank r13, r14 and SPSR. The
// 38 physical registers live in one RAM with a registered read; a bank of 38
// valid bits, cleared by reset, makes never-written registers read as zero,
// so no clearing pass is needed after reset. The block takes one item per
// cycle while in_stall is low; an accepted item passes through the read stage
// (RAM read) and then the output register. A mode change takes effect for the
// very next item. Index above 17 on a read or write, or a change to mode 6 or
// 7, sets error and writes nothing (the invalid mode is still stored and maps
// like user mode). Input stall rises only when the result path is full and
// the output is stalled, and is held high during reset.
module banked_register_file_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  brf_pkg::brf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output brf_pkg::brf_out_t out_data
);

  import brf_pkg::*;

  logic [MODE_W-1:0]     mode_r, mode_nxt;
  logic [PHYS_COUNT-1:0] valid_r, valid_nxt;

  // Read stage: item whose RAM read is in flight.
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_read_r, s1_read_nxt;
  logic                  s1_hit_r, s1_hit_nxt;
  logic                  s1_err_r, s1_err_nxt;

  // Output register.
  logic                  out_valid_r, out_valid_nxt;
  brf_out_t              out_data_r, out_data_nxt;

  logic                  accept;
  logic                  advance;
  logic                  idx_bad;
  logic [SLOT_W-1:0]     slot;
  logic                  wr_en;
  logic                  rd_en;
  logic                  cmd_err;
  logic [DATA_WIDTH-1:0] ram_rd_data;

  // Move the read stage into the output register when it is free or drains.
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = !rst_n || (s1_valid_r && !advance);
  assign accept   = in_valid && !in_stall;

  assign idx_bad  = in_data.reg_index > LAST_INDEX;
  assign slot     = brf_slot(in_data.reg_index, mode_r);

  always_comb begin
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    cmd_err = 1'b0;
    unique case (in_data.func)
      FUNC_READ: begin
        rd_en   = accept && !idx_bad;
        cmd_err = idx_bad;
      end
      FUNC_WRITE: begin
        wr_en   = accept && !idx_bad;
        cmd_err = idx_bad;
      end
      FUNC_MODE: begin
        cmd_err = in_data.new_mode > MODE_LAST;
      end
      FUNC_NONE: begin
        cmd_err = 1'b0;
      end
    endcase
  end

  brf_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (PHYS_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot),
    .wr_data (in_data.write_data),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    mode_nxt      = mode_r;
    valid_nxt     = valid_r;
    s1_valid_nxt  = s1_valid_r;
    s1_read_nxt   = s1_read_r;
    s1_hit_nxt    = s1_hit_r;
    s1_err_nxt    = s1_err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the result once taken.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Unwritten registers read as zero.
    if (advance) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.error     = s1_err_r;
      out_data_nxt.read_data = (s1_read_r && s1_hit_r) ? ram_rd_data : '0;
      s1_valid_nxt           = 1'b0;
    end

    if (accept) begin
      s1_valid_nxt = 1'b1;
      s1_read_nxt  = rd_en;
      s1_hit_nxt   = valid_r[slot];
      s1_err_nxt   = cmd_err;
      if (wr_en) begin
        valid_nxt[slot] = 1'b1;
      end
      if (in_data.func == FUNC_MODE) begin
        mode_nxt = in_data.new_mode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_USER;
      valid_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      valid_r     <= valid_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk) begin
    s1_read_r  <= s1_read_nxt;
    s1_hit_r   <= s1_hit_nxt;
    s1_err_r   <= s1_err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/brf_checker.sv
// Port-level assertions for the banked register file, bound to the top level.
`include "assert_macros.svh"

module brf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input brf_pkg::brf_out_t out_data
);

  import brf_pkg::*;

  // A stalled result holds.
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // A flagged item never carries read data.
  `ASSERT_IMPL(a_err_zero, out_valid && out_data.error, out_data.read_data == '0)

  // A fresh result comes from an accepted item that has passed through the read stage.
  `ASSERT_IMPL(a_rise_src, $rose(out_valid), $past(in_valid && !in_stall, 2))

endmodule

bind banked_register_file_top brf_checker u_brf_checker (.*);

// File: bench/tb_banked_register_file_top.sv
// Self-checking testbench for the mode-banked register file.
`timescale 1ns / 1ps

module tb_banked_register_file_top;
  import brf_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  brf_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  brf_out_t out_data;

  // Percent of cycles on which each side holds off; changed between phases.
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;

  // Shadow of the register file: physical slots and the current mode.
  logic [DATA_WIDTH-1:0] shadow_regs [PHYS_COUNT];
  logic [MODE_W-1:0]     shadow_mode;

  // Responses predicted for accepted items, oldest first.
  brf_out_t pending_responses [$];
  int unsigned mismatch_count = 0;

  banked_register_file_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Map a logical index to its physical slot under the given mode. FIQ banks
  // r8..r14 and SPSR; SVC, abort, IRQ and undefined bank r13, r14 and SPSR in
  // groups of three. User mode and the invalid modes use the plain slots.
  function automatic logic [SLOT_W-1:0] bank_slot(logic [IDX_W-1:0] idx,
                                                  logic [MODE_W-1:0] mode);
    logic [SLOT_W-1:0] group_base;
    bank_slot = SLOT_W'(idx);
    if (mode == MODE_FIQ) begin
      if (idx >= IDX_R8 && idx <= IDX_R14) begin
        bank_slot = FIQ_R8_SLOT + SLOT_W'(idx - IDX_R8);
      end else if (idx == IDX_SPSR) begin
        bank_slot = FIQ_SPSR_SLOT;
      end
    end else if (mode >= MODE_SVC && mode <= MODE_UND) begin
      group_base = SVC_BASE + SLOT_W'(3 * int'(mode - MODE_SVC));
      if (idx == IDX_R13) begin
        bank_slot = group_base;
      end else if (idx == IDX_R14) begin
        bank_slot = group_base + SLOT_W'(1);
      end else if (idx == IDX_SPSR) begin
        bank_slot = group_base + SLOT_W'(2);
      end
    end
  endfunction

  // Apply one item to the shadow state and return the response it causes.
  function automatic brf_out_t register_file_response(brf_in_t item);
    brf_out_t          resp;
    logic [SLOT_W-1:0] slot;
    resp = '0;
    case (item.func)
      FUNC_READ, FUNC_WRITE: begin
        if (item.reg_index > LAST_INDEX) begin
          // Out-of-range index: flag it, touch nothing.
          resp.error = 1'b1;
        end else begin
          slot = bank_slot(item.reg_index, shadow_mode);
          if (item.func == FUNC_READ) begin
            resp.read_data = shadow_regs[slot];
          end else begin
            shadow_regs[slot] = item.write_data;
          end
        end
      end
      FUNC_MODE: begin
        // An invalid mode is still stored; it maps like user mode.
        shadow_mode = item.new_mode;
        resp.error  = (item.new_mode > MODE_LAST);
      end
      default: begin
      end
    endcase
    return resp;
  endfunction

  function automatic brf_in_t make_item(brf_func_t f, logic [IDX_W-1:0] idx,
                                        logic [DATA_WIDTH-1:0] data,
                                        logic [MODE_W-1:0] mode);
    brf_in_t item;
    item.func       = f;
    item.reg_index  = idx;
    item.write_data = data;
    item.new_mode   = mode;
    return item;
  endfunction

  // Mostly well-formed accesses to real registers and valid modes, with a
  // share of out-of-range indexes, invalid modes and the unused function code.
  function automatic brf_in_t random_item();
    brf_in_t               item;
    int unsigned           pick;
    logic [DATA_WIDTH-1:0] data;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       data = '0;
      1:       data = '1;
      default: data = DATA_WIDTH'($urandom);
    endcase
    item = make_item(FUNC_NONE,
                     ($urandom_range(9) == 0) ? IDX_W'($urandom_range(31, 18))
                                              : IDX_W'($urandom_range(17)),
                     data,
                     ($urandom_range(9) == 0) ? MODE_W'($urandom_range(7, 6))
                                              : MODE_W'($urandom_range(5)));
    if (pick < 40) begin
      item.func = FUNC_READ;
    end else if (pick < 75) begin
      item.func = FUNC_WRITE;
    end else if (pick < 95) begin
      item.func = FUNC_MODE;
    end
    return item;
  endfunction

  // Present one item, holding it until the block takes it, then record the
  // response it should produce. Idle cycles go in front of the item.
  task automatic send_item(brf_in_t item);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_responses.push_back(register_file_response(item));
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  // Receiver: stall at random at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Compare every accepted result with the oldest prediction. The values read
  // here are those from before the edge, the same ones the block sees.
  always @(posedge clk) begin
    brf_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected result read_data=%h error=%b",
                                  out_data.read_data, out_data.error));
      end else begin
        want = pending_responses.pop_front();
        if (out_data.read_data !== want.read_data) begin
          report_mismatch($sformatf("read_data expected %h, got %h",
                                    want.read_data, out_data.read_data));
        end
        if (out_data.error !== want.error) begin
          report_mismatch($sformatf("error expected %b, got %b",
                                    want.error, out_data.error));
        end
      end
    end
  end

  // Register 0 and SPSR read as zero after reset; indexes past SPSR are
  // flagged.
  task automatic test_reset_contents();
    send_item(make_item(FUNC_READ, 5'd0, '0, MODE_USER));
    send_item(make_item(FUNC_READ, IDX_SPSR, '0, MODE_USER));
    send_item(make_item(FUNC_READ, 5'd31, '1, 3'd7));
    send_item(make_item(FUNC_WRITE, 5'd18, '1, MODE_USER));
  endtask

  // Walk through user, FIQ and SVC modes and check that each bank stays separate.
  task automatic test_mode_banking();
    send_item(make_item(FUNC_WRITE, 5'd0, '1, MODE_USER));
    send_item(make_item(FUNC_READ, 5'd0, '0, MODE_USER));
    send_item(make_item(FUNC_WRITE, IDX_SPSR, 32'hA5A5_A5A5, MODE_USER));
    send_item(make_item(FUNC_WRITE, IDX_R8, 32'h1357_9BDF, MODE_USER));
    send_item(make_item(FUNC_MODE, 5'd0, '0, MODE_FIQ));
    send_item(make_item(FUNC_WRITE, IDX_R8, 32'h0000_0001, MODE_USER));
    send_item(make_item(FUNC_READ, IDX_R8, '0, MODE_USER));
    send_item(make_item(FUNC_READ, IDX_SPSR, '0, MODE_USER));
    // Entering SVC must not copy CPSR into its SPSR.
    send_item(make_item(FUNC_WRITE, 5'd16, 32'h0000_001F, MODE_USER));
    send_item(make_item(FUNC_MODE, 5'd0, '0, MODE_SVC));
    send_item(make_item(FUNC_READ, IDX_SPSR, '0, MODE_USER));
    send_item(make_item(FUNC_WRITE, IDX_R13, 32'h8000_0000, MODE_USER));
    send_item(make_item(FUNC_READ, IDX_R13, '0, MODE_USER));
    // A CPSR write only stores the value; the mode stays SVC.
    send_item(make_item(FUNC_WRITE, 5'd16, 32'h0000_0010, MODE_USER));
    send_item(make_item(FUNC_READ, IDX_R13, '0, MODE_USER));
    send_item(make_item(FUNC_MODE, 5'd0, '0, MODE_USER));
    send_item(make_item(FUNC_READ, IDX_R8, '0, MODE_USER));
    send_item(make_item(FUNC_READ, 5'd16, '0, MODE_USER));
  endtask

  // Invalid modes are flagged once, then map like user mode; the unused
  // function code does nothing.
  task automatic test_invalid_modes();
    send_item(make_item(FUNC_MODE, 5'd0, '0, 3'd6));
    send_item(make_item(FUNC_READ, IDX_SPSR, '0, MODE_USER));
    send_item(make_item(FUNC_READ, IDX_R13, '0, MODE_USER));
    send_item(make_item(FUNC_MODE, 5'd31, '1, 3'd7));
    send_item(make_item(FUNC_NONE, 5'd31, '1, 3'd7));
  endtask

  task automatic test_random_traffic(int unsigned count);
    repeat (count) send_item(random_item());
  endtask

  initial begin
    for (int i = 0; i < PHYS_COUNT; i++) shadow_regs[i] = '0;
    shadow_mode = MODE_USER;

    // Drive all inputs and hold reset.
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Phase one: sender idles often, receiver stalls most of the time.
    sender_idle_pct    = 32;
    receiver_stall_pct = 70;
    test_reset_contents();
    test_mode_banking();
    test_random_traffic(230);

    // Phase two: swap the pressure.
    sender_idle_pct    = 70;
    receiver_stall_pct = 32;
    test_invalid_modes();
    test_random_traffic(230);

    // Phase three: run back to back.
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    test_random_traffic(240);
    in_valid <= 1'b0;

    // Drain, then wait on so that the two-stage pipeline can show any stray
    // result.
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run; this is many times the slowest legal run.
  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/brf_pkg.sv
design/brf_ram.sv
design/banked_register_file_top.sv
design/brf_checker.sv
bench/tb_banked_register_file_top.sv
